### rtl/core/cppid_pkg.sv
// ----------------------------------------------------------------------------
// cppid_pkg
// Shared types and constants for the cascaded position/current PID core.
// ----------------------------------------------------------------------------
package cppid_pkg;

    localparam int unsigned PWM_TOP     = 4095;
    localparam bit          DIR_REVERSE = 1'b0;
    localparam int unsigned PI_Q16      = 205887;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 50;
    localparam int SUM_W  = 56;
    localparam int U_W    = 31;

    typedef struct packed {
        logic        [13:0] angle_raw;
        logic signed [15:0] current_meas;
    } in_t;

    typedef struct packed {
        logic        [11:0] duty_forward;
        logic        [11:0] duty_reverse;
        logic signed [15:0] position;
        logic signed [15:0] current_ref;
    } out_t;

    typedef enum logic [2:0] {
        CFG_REF_POSITION,
        CFG_POS_KP,
        CFG_POS_KI,
        CFG_POS_KD,
        CFG_CUR_KP,
        CFG_CUR_KI,
        CFG_CURRENT_LIMIT,
        CFG_STEP_TIME
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MUL_ANGLE,
        MUL_ERR_STEP,
        MUL_ERR_KP,
        MUL_DER_KD,
        MUL_PINT_KI,
        MUL_U_LIM,
        MUL_ERRI_STEP,
        MUL_ERRI_KP,
        MUL_CINT_KI,
        MUL_DUTY
    } mul_sel_t;

    typedef enum logic [3:0] {
        UPD_NONE,
        UPD_CAPTURE,
        UPD_ERR,
        UPD_PINT,
        UPD_ACC_LOAD,
        UPD_ACC_ADD,
        UPD_U_POS,
        UPD_IREF,
        UPD_CINT,
        UPD_U_CUR,
        UPD_DUTY
    } upd_t;

    typedef struct packed {
        upd_t     upd;
        mul_sel_t mul_sel;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG,
        ST_ERR,
        ST_PI_MUL,
        ST_PINT,
        ST_KP,
        ST_KD,
        ST_KI,
        ST_ULIM,
        ST_IREF,
        ST_CI_MUL,
        ST_CINT,
        ST_CKP,
        ST_CKI,
        ST_DUTY_MUL,
        ST_OUT
    } state_t;

endpackage

### rtl/core/cascaded_position_current_pid_core.sv
// ----------------------------------------------------------------------------
// cascaded_position_current_pid_core
// Cascaded position PID / current PI controller, one control tick per item.
// ----------------------------------------------------------------------------
// Each input transfer carries one encoder angle and one current sample; each
// produces exactly one result transfer with the PWM compare values, the
// corrected position and the current reference. The whole tick runs through
// one shared 33x33 multiplier, one product per cycle, along a chain of ten
// dependent multiplies with their update steps; a new item is taken only once
// the previous tick has finished. The result sits in an output register, so
// the next item is accepted while a result still waits; that item then holds
// its finished result until the output register is free. Configuration
// writes are registered and are meant to be issued only while the core is
// idle.
module cascaded_position_current_pid_core
    import cppid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    cppid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cppid_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### rtl/core/cppid_ctrl.sv
// ----------------------------------------------------------------------------
// cppid_ctrl
// Sequencer for one control tick; owns the input and output handshakes.
// ----------------------------------------------------------------------------
module cppid_ctrl
    import cppid_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.upd        = UPD_NONE;
        cmd.mul_sel    = MUL_DUTY;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.upd    = UPD_CAPTURE;
                    state_next = ST_ANG;
                end
            end
            ST_ANG:
            begin
                cmd.mul_sel = MUL_ANGLE;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.upd    = UPD_ERR;
                state_next = ST_PI_MUL;
            end
            ST_PI_MUL:
            begin
                cmd.mul_sel = MUL_ERR_STEP;
                state_next  = ST_PINT;
            end
            ST_PINT:
            begin
                cmd.upd     = UPD_PINT;
                cmd.mul_sel = MUL_ERR_KP;
                state_next  = ST_KP;
            end
            ST_KP:
            begin
                cmd.upd     = UPD_ACC_LOAD;
                cmd.mul_sel = MUL_DER_KD;
                state_next  = ST_KD;
            end
            ST_KD:
            begin
                cmd.upd     = UPD_ACC_ADD;
                cmd.mul_sel = MUL_PINT_KI;
                state_next  = ST_KI;
            end
            ST_KI:
            begin
                cmd.upd    = UPD_U_POS;
                state_next = ST_ULIM;
            end
            ST_ULIM:
            begin
                cmd.mul_sel = MUL_U_LIM;
                state_next  = ST_IREF;
            end
            ST_IREF:
            begin
                cmd.upd    = UPD_IREF;
                state_next = ST_CI_MUL;
            end
            ST_CI_MUL:
            begin
                cmd.mul_sel = MUL_ERRI_STEP;
                state_next  = ST_CINT;
            end
            ST_CINT:
            begin
                cmd.upd     = UPD_CINT;
                cmd.mul_sel = MUL_ERRI_KP;
                state_next  = ST_CKP;
            end
            ST_CKP:
            begin
                cmd.upd     = UPD_ACC_LOAD;
                cmd.mul_sel = MUL_CINT_KI;
                state_next  = ST_CKI;
            end
            ST_CKI:
            begin
                cmd.upd    = UPD_U_CUR;
                state_next = ST_DUTY_MUL;
            end
            ST_DUTY_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.upd        = UPD_DUTY;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/cppid_dp.sv
// ----------------------------------------------------------------------------
// cppid_dp
// Datapath: configuration registers, loop state, shared multiplier, result.
// ----------------------------------------------------------------------------
module cppid_dp
    import cppid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  in_t         in_data,
    output out_t        out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic signed [15:0] ref_position_reg;
    logic signed [31:0] pos_kp_reg;
    logic signed [31:0] pos_ki_reg;
    logic signed [31:0] pos_kd_reg;
    logic signed [31:0] cur_kp_reg;
    logic signed [31:0] cur_ki_reg;
    logic        [14:0] current_limit_reg;
    logic        [15:0] step_time_reg;

    // loop state
    logic signed [31:0] pint_reg, pint_next;
    logic signed [15:0] prev_reg, prev_next;
    logic signed [31:0] cint_reg, cint_next;

    // working registers
    logic        [13:0]       raw_reg, raw_next;
    logic signed [15:0]       imeas_reg, imeas_next;
    logic signed [15:0]       pos_reg, pos_next;
    logic signed [15:0]       err_reg, err_next;
    logic signed [16:0]       deriv_reg, deriv_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [U_W-1:0]    u_reg, u_next;
    logic signed [15:0]       iref_reg, iref_next;
    logic signed [16:0]       erri_reg, erri_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    out_t                     res_reg, res_next;

    // multiplier
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_full;

    logic               ang_wrap;
    logic        [14:0] ang_mag;
    logic        [31:0] ang_rnd;
    logic        [15:0] mag16;
    logic signed [15:0] pos_c;
    logic signed [16:0] diff17;
    logic signed [PROD_W-1:0] pinc;
    logic signed [33:0] psum;
    logic signed [SUM_W-1:0]  usum;
    logic signed [46:0] iref_t;
    logic signed [33:0] csum;
    logic signed [U_W-1:0]    u_abs;
    logic        [11:0] duty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_position_reg  <= '0;
            pos_kp_reg        <= '0;
            pos_ki_reg        <= '0;
            pos_kd_reg        <= '0;
            cur_kp_reg        <= '0;
            cur_ki_reg        <= '0;
            current_limit_reg <= '0;
            step_time_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_REF_POSITION:  ref_position_reg  <= cfg_data[15:0];
                CFG_POS_KP:        pos_kp_reg        <= cfg_data;
                CFG_POS_KI:        pos_ki_reg        <= cfg_data;
                CFG_POS_KD:        pos_kd_reg        <= cfg_data;
                CFG_CUR_KP:        cur_kp_reg        <= cfg_data;
                CFG_CUR_KI:        cur_ki_reg        <= cfg_data;
                CFG_CURRENT_LIMIT: current_limit_reg <= cfg_data[14:0];
                CFG_STEP_TIME:     step_time_reg     <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pint_reg <= '0;
            prev_reg <= '0;
            cint_reg <= '0;
        end
        else
        begin
            pint_reg <= pint_next;
            prev_reg <= prev_next;
            cint_reg <= cint_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg   <= raw_next;
        imeas_reg <= imeas_next;
        pos_reg   <= pos_next;
        err_reg   <= err_next;
        deriv_reg <= deriv_next;
        acc_reg   <= acc_next;
        u_reg     <= u_next;
        iref_reg  <= iref_next;
        erri_reg  <= erri_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
    end

    // operand selection
    assign ang_wrap = (raw_reg > 14'd8192);
    assign ang_mag  = ang_wrap ? (15'd16384 - {1'b0, raw_reg}) : {1'b0, raw_reg};
    assign u_abs    = u_reg[U_W-1] ? -u_reg : u_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_ANGLE:
            begin
                mul_a = MUL_W'(ang_mag);
                mul_b = MUL_W'(PI_Q16);
            end
            MUL_ERR_STEP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(step_time_reg);
            end
            MUL_ERR_KP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(pos_kp_reg);
            end
            MUL_DER_KD:
            begin
                mul_a = MUL_W'(deriv_reg);
                mul_b = MUL_W'(pos_kd_reg);
            end
            MUL_PINT_KI:
            begin
                mul_a = MUL_W'(pint_reg);
                mul_b = MUL_W'(pos_ki_reg);
            end
            MUL_U_LIM:
            begin
                mul_a = MUL_W'(u_reg);
                mul_b = MUL_W'(current_limit_reg);
            end
            MUL_ERRI_STEP:
            begin
                mul_a = MUL_W'(erri_reg);
                mul_b = MUL_W'(step_time_reg);
            end
            MUL_ERRI_KP:
            begin
                mul_a = MUL_W'(erri_reg);
                mul_b = MUL_W'(cur_kp_reg);
            end
            MUL_CINT_KI:
            begin
                mul_a = MUL_W'(cint_reg);
                mul_b = MUL_W'(cur_ki_reg);
            end
            MUL_DUTY:
            begin
                mul_a = MUL_W'(u_abs);
                mul_b = MUL_W'(PWM_TOP);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full  = mul_a * mul_b;
    assign prod_next = mul_full[PROD_W-1:0];

    // angle rounding and position error
    assign ang_rnd = prod_reg[31:0] + 32'd32768;
    assign mag16   = ang_rnd[31:16];
    assign pos_c   = (ang_wrap ^ DIR_REVERSE) ? -$signed(mag16) : $signed(mag16);
    assign diff17  = 17'(ref_position_reg) - 17'(pos_c);

    // position integrator, Q8.24
    assign pinc = (prod_reg + 64'sd16) >>> 5;
    assign psum = 34'(pint_reg) + 34'(pinc);

    // loop output sums
    assign usum = (cmd.upd == UPD_U_POS) ? (SUM_W'(acc_reg) + SUM_W'(prod_reg >>> 11))
                                         : (SUM_W'(acc_reg) + SUM_W'(prod_reg >>> 16));

    assign iref_t = 47'(prod_reg) + 47'sd268435456;
    assign csum   = 34'(cint_reg) + 34'($signed(prod_reg[32:0]));
    assign duty   = prod_reg[39:28];

    always_comb
    begin
        raw_next   = raw_reg;
        imeas_next = imeas_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        deriv_next = deriv_reg;
        acc_next   = acc_reg;
        u_next     = u_reg;
        iref_next  = iref_reg;
        erri_next  = erri_reg;
        res_next   = res_reg;
        pint_next  = pint_reg;
        prev_next  = prev_reg;
        cint_next  = cint_reg;
        unique case (cmd.upd)
            UPD_NONE:
            begin
            end
            UPD_CAPTURE:
            begin
                raw_next   = in_data.angle_raw;
                imeas_next = in_data.current_meas;
            end
            UPD_ERR:
            begin
                pos_next = pos_c;
                priority if (diff17 > 17'sd32767)
                    err_next = 16'sh7FFF;
                else if (diff17 < -17'sd32768)
                    err_next = 16'sh8000;
                else
                    err_next = diff17[15:0];
            end
            UPD_PINT:
            begin
                priority if (psum > 34'sd2147483647)
                    pint_next = 32'sh7FFF_FFFF;
                else if (psum < -34'sd2147483648)
                    pint_next = 32'sh8000_0000;
                else
                    pint_next = psum[31:0];
                deriv_next = 17'(err_reg) - 17'(prev_reg);
                prev_next  = err_reg;
            end
            UPD_ACC_LOAD:
            begin
                acc_next = ACC_W'(prod_reg);
            end
            UPD_ACC_ADD:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
            UPD_U_POS:
            begin
                priority if (usum > 56'sd536870912)
                    u_next = 31'sd536870912;
                else if (usum < -56'sd536870912)
                    u_next = -31'sd536870912;
                else
                    u_next = usum[U_W-1:0];
            end
            UPD_IREF:
            begin
                iref_next = iref_t[44:29];
                erri_next = 17'($signed(iref_t[44:29])) - 17'(imeas_reg);
            end
            UPD_CINT:
            begin
                priority if (csum > 34'sd1342177280)
                    cint_next = 32'sd1342177280;
                else if (csum < -34'sd1342177280)
                    cint_next = -32'sd1342177280;
                else
                    cint_next = csum[31:0];
            end
            UPD_U_CUR:
            begin
                priority if (usum > 56'sd268435456)
                    u_next = 31'sd268435456;
                else if (usum < -56'sd268435456)
                    u_next = -31'sd268435456;
                else
                    u_next = usum[U_W-1:0];
            end
            UPD_DUTY:
            begin
                res_next.duty_forward = (u_reg > 31'sd0) ? duty : 12'd0;
                res_next.duty_reverse = (u_reg < 31'sd0) ? duty : 12'd0;
                res_next.position     = pos_reg;
                res_next.current_ref  = iref_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_data = res_reg;

endmodule

### test/cascaded_position_current_pid_core_tb.sv
// ----------------------------------------------------------------------------
// cascaded_position_current_pid_core_tb
// Self-checking bench for the cascaded position PID / current PI core.
// ----------------------------------------------------------------------------
// A clocked driver feeds encoder/current samples from a queue, and a clocked
// monitor predicts each control tick as the input transfer happens, then
// checks every result field against the oldest prediction. Gains are loaded
// while the core is idle: a directed part with corner angles, currents and
// saturating gain sets, then random gain sets with random samples, under
// varying sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module cascaded_position_current_pid_core_tb;
    import cppid_pkg::*;

    localparam longint ANGLE_PI = longint'(PI_Q16);
    localparam longint DUTY_TOP = longint'(PWM_TOP);
    localparam longint ONE28    = 64'sd1 <<< 28;
    localparam longint ONE29    = 64'sd1 <<< 29;
    localparam longint I32_MAX  = 64'sd2147483647;
    localparam longint I32_MIN  = -64'sd2147483648;
    localparam int     STALL_LIMIT = 3000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // controller registers and loop state as the core should hold them
    longint tgt_angle = 0, pos_kp = 0, pos_ki = 0, pos_kd = 0;
    longint cur_kp = 0, cur_ki = 0, i_limit = 0, dt = 0;
    longint pos_int = 0, err_prev = 0, cur_int = 0;

    in_t  sample_q[$];
    out_t drive_q[$];
    int   queued_count = 0;
    int   got_count = 0;
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    logic in_took = 1'b0;

    cascaded_position_current_pid_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic out_t control_tick(in_t s);
        longint raw, imeas, pos, err, deriv, u, iref, erri;
        out_t   r;
        raw   = longint'(s.angle_raw);
        imeas = longint'($signed(s.current_meas));
        if (raw > 8192)
            pos = -(((16384 - raw) * ANGLE_PI + 32768) >>> 16);
        else
            pos = (raw * ANGLE_PI + 32768) >>> 16;
        if (DIR_REVERSE)
            pos = -pos;

        err     = sat(tgt_angle - pos, -32768, 32767);
        pos_int = sat(pos_int + ((err * dt + 16) >>> 5), I32_MIN, I32_MAX);
        deriv   = err - err_prev;
        err_prev = err;
        u    = err * pos_kp + ((pos_int * pos_ki) >>> 11) + deriv * pos_kd;
        u    = sat(u, -ONE29, ONE29);
        iref = (u * i_limit + ONE28) >>> 29;

        erri    = iref - imeas;
        cur_int = sat(cur_int + erri * dt, -5 * ONE28, 5 * ONE28);
        u = erri * cur_kp + ((cur_int * cur_ki) >>> 16);
        u = sat(u, -ONE28, ONE28);

        r = '0;
        if (u > 0)
            r.duty_forward = 12'((u * DUTY_TOP) >>> 28);
        else if (u < 0)
            r.duty_reverse = 12'(((-u) * DUTY_TOP) >>> 28);
        r.position    = 16'(pos);
        r.current_ref = 16'(iref);
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint seen);
        if (want != seen)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
            mismatch_count++;
        end
    endtask

    // driver: new sample only once the previous one has transferred
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                in_valid <= 1'b1;
                in_data  <= sample_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        out_t want;
        in_took <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_REF_POSITION:  tgt_angle = longint'($signed(cfg_data[15:0]));
                    CFG_POS_KP:        pos_kp    = longint'($signed(cfg_data));
                    CFG_POS_KI:        pos_ki    = longint'($signed(cfg_data));
                    CFG_POS_KD:        pos_kd    = longint'($signed(cfg_data));
                    CFG_CUR_KP:        cur_kp    = longint'($signed(cfg_data));
                    CFG_CUR_KI:        cur_ki    = longint'($signed(cfg_data));
                    CFG_CURRENT_LIMIT: i_limit   = longint'(cfg_data[14:0]);
                    CFG_STEP_TIME:     dt        = longint'(cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    $display("%0t: result with no tick pending, got %h", $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    got_count++;
                    check_field("duty_forward", want.duty_forward, out_data.duty_forward);
                    check_field("duty_reverse", want.duty_reverse, out_data.duty_reverse);
                    check_field("position", want.position, out_data.position);
                    check_field("current_ref", want.current_ref, out_data.current_ref);
                end
            end
            if (in_valid && !in_stall)
                drive_q.push_back(control_tick(in_data));

            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(cfg_reg_t sel, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_gains(logic [31:0] tgt, logic [31:0] pkp, logic [31:0] pki,
                              logic [31:0] pkd, logic [31:0] ckp, logic [31:0] cki,
                              logic [31:0] lim, logic [31:0] st);
        write_reg(CFG_REF_POSITION, tgt);
        write_reg(CFG_POS_KP, pkp);
        write_reg(CFG_POS_KI, pki);
        write_reg(CFG_POS_KD, pkd);
        write_reg(CFG_CUR_KP, ckp);
        write_reg(CFG_CUR_KI, cki);
        write_reg(CFG_CURRENT_LIMIT, lim);
        write_reg(CFG_STEP_TIME, st);
    endtask

    task automatic queue_tick(logic [13:0] angle, logic [15:0] cur);
        sample_q.push_back('{angle_raw: angle, current_meas: cur});
        queued_count++;
    endtask

    task automatic drain();
        while (got_count != queued_count)
            @(negedge clk);
    endtask

    // spread of magnitudes so that both linear and saturated loops show up
    function automatic logic [31:0] rand_gain();
        logic [31:0] g;
        g = $urandom >> $urandom_range(31, 0);
        if ($urandom_range(1))
            g = -g;
        return g;
    endfunction

    initial
    begin
        int          tgt;
        int          near_raw;
        logic [13:0] angle;
        logic [15:0] cur;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // moderate gains, corner angles and currents
        load_gains(32'd0, 32'h1000, 32'h800, 32'h4000, 32'h2000, 32'h1000,
                   32'd16384, 32'd655);
        queue_tick(14'd0,     16'h0000);
        queue_tick(14'd1,     16'h7FFF);
        queue_tick(14'd4096,  16'h8000);
        queue_tick(14'd8191,  16'h0001);
        queue_tick(14'd8192,  16'hFFFF);
        queue_tick(14'd8193,  16'h1000);
        queue_tick(14'd12288, 16'hF000);
        queue_tick(14'd16383, 16'h0000);
        drain();

        // largest positive settings: error and current integrator saturate
        load_gains(32'd25736, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'd32767, 32'd65535);
        queue_tick(14'd8193,  16'h8000);
        queue_tick(14'd16383, 16'h7FFF);
        queue_tick(14'd0,     16'h8000);
        queue_tick(14'd8192,  16'h7FFF);
        queue_tick(14'd12000, 16'h0000);
        queue_tick(14'd9000,  16'h8000);
        drain();

        // most negative settings, zero limit and zero step time
        load_gains(-32'sd25736, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'd0, 32'd0);
        queue_tick(14'd8192,  16'h7FFF);
        queue_tick(14'd0,     16'h8000);
        queue_tick(14'd8193,  16'h0000);
        queue_tick(14'd16383, 16'h5A5A);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 82; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 82; end
                default: begin send_idle = 28; recv_stall = 28; end
            endcase
            if ($urandom_range(2) == 0)
                tgt = $urandom_range(1) ? 25736 : -25736;
            else
                tgt = int'($urandom_range(51472)) - 25736;
            load_gains(32'(tgt), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                       rand_gain(), $urandom_range(32767),
                       ($urandom_range(2) == 0) ? 32'd65535 : $urandom_range(65535));
            near_raw = (tgt * 65536) / 205887 + 16384;
            for (int i = 0; i < 75; i++)
            begin
                if ($urandom_range(3) != 0)
                    angle = 14'(near_raw + int'($urandom_range(128)) - 64);
                else
                    angle = 14'($urandom);
                cur = 16'($urandom);
                if ($urandom_range(1))
                    cur = $signed(cur) >>> $urandom_range(15, 4);
                queue_tick(angle, cur);
            end
            drain();
        end

        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && drive_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/core/cppid_pkg.sv
rtl/core/cppid_ctrl.sv
rtl/core/cppid_dp.sv
rtl/core/cascaded_position_current_pid_core.sv
test/cascaded_position_current_pid_core_tb.sv
